// File: rtl/evq_pkg.sv
package evq_pkg;

    // Field widths of the stream payloads.
    localparam int CMD_W      = 2;
    localparam int TYPE_W     = 8;
    localparam int PARAM_W    = 16;
    localparam int HID_W      = 8;
    localparam int STATUS_W   = 3;
    localparam int QCOUNT_W   = 6;
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 40;

    // Commands carried on the slave-side tuser.
    typedef enum logic [CMD_W-1:0] {
        CMD_POST        = 2'd0,
        CMD_DISPATCH    = 2'd1,
        CMD_SUBSCRIBE   = 2'd2,
        CMD_UNSUBSCRIBE = 2'd3
    } cmd_e;

    // Result status codes carried on the master-side tuser.
    typedef enum logic [STATUS_W-1:0] {
        STAT_OK         = 3'd0,
        STAT_QUEUE_FULL = 3'd1,
        STAT_TABLE_FULL = 3'd2,
        STAT_NO_HANDLER = 3'd3,
        STAT_EMPTY      = 3'd4,
        STAT_TYPE_ZERO  = 3'd5
    } status_e;

    // How the output register is filled.
    typedef enum logic [1:0] {
        EM_NONE  = 2'd0,
        EM_PLAIN = 2'd1,
        EM_HIT   = 2'd2,
        EM_MISS  = 2'd3
    } emit_e;

    // Controller states.
    typedef enum logic [1:0] {
        S_IDLE  = 2'd0,
        S_SCAN  = 2'd1,
        S_FINAL = 2'd2
    } state_e;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    accept;
        logic    q_push;
        logic    q_pop;
        logic    scan_start;
        logic    scan_step;
        logic    slot_write;
        logic    slot_free;
        logic    hold_load;
        logic    found_set;
        emit_e   emit;
        status_e emit_status;
        logic    emit_last;
    } evq_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
        logic q_empty;
        logic q_full;
        logic in_type_zero;
        logic disp_hit;
        logic free_hit;
        logic unsub_hit;
        logic chk_end;
        logic hold_valid;
        logic found;
    } evq_stat_t;

endpackage

// File: rtl/evq_datapath.sv
module evq_datapath #(
    parameter int QUEUE_DEPTH = 32,
    parameter int TABLE_SLOTS = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [evq_pkg::IN_DATA_W-1:0] s_tdata,
    input  evq_pkg::evq_cmd_t             cmd,
    output evq_pkg::evq_stat_t            stat,
    input  logic                          m_tready,
    output logic                          m_tvalid,
    output logic [evq_pkg::OUT_DATA_W-1:0] m_tdata,
    output logic [evq_pkg::STATUS_W-1:0]  m_tuser,
    output logic                          m_tlast
);
    import evq_pkg::*;

    localparam int QIW     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW      = $clog2(QUEUE_DEPTH + 1);
    localparam int SLOT_IW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam logic [QIW-1:0]     LAST_Q    = QIW'(QUEUE_DEPTH - 1);
    localparam logic [CW-1:0]      FULL_CNT  = CW'(QUEUE_DEPTH);
    localparam logic [SLOT_IW-1:0] LAST_SLOT = SLOT_IW'(TABLE_SLOTS - 1);

    // Input fields.
    logic [TYPE_W-1:0]  in_type;
    logic [PARAM_W-1:0] in_param;
    logic [HID_W-1:0]   in_hid;

    assign in_type  = s_tdata[TYPE_W-1:0];
    assign in_param = s_tdata[TYPE_W+PARAM_W-1:TYPE_W];
    assign in_hid   = s_tdata[TYPE_W+PARAM_W+HID_W-1:TYPE_W+PARAM_W];

    // Event queue storage and pointers.
    logic [TYPE_W-1:0]  q_type_mem  [QUEUE_DEPTH];
    logic [PARAM_W-1:0] q_param_mem [QUEUE_DEPTH];
    logic [QIW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [QIW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [TYPE_W-1:0]  ev_type_reg;
    logic [PARAM_W-1:0] ev_param_reg;

    // Subscriber table storage and scan stage.
    logic [TYPE_W-1:0]      sl_type_mem [TABLE_SLOTS];
    logic [HID_W-1:0]       sl_hid_mem  [TABLE_SLOTS];
    logic [TABLE_SLOTS-1:0] vld_reg;
    logic                   sl_vld_reg;
    logic [TYPE_W-1:0]      sl_type_reg;
    logic [HID_W-1:0]       sl_hid_reg;
    logic [SLOT_IW-1:0]     chk_idx_reg;
    logic [SLOT_IW-1:0]     sl_rd_addr;
    logic                   sl_rd_en;

    // Request latched at acceptance, and scan results.
    logic [TYPE_W-1:0] req_type_reg;
    logic [HID_W-1:0]  req_hid_reg;
    logic              hold_valid_reg;
    logic [HID_W-1:0]  hold_hid_reg;
    logic              found_reg;

    // Output register.
    logic                out_valid_reg;
    status_e             out_status_reg;
    logic [TYPE_W-1:0]   out_type_reg;
    logic [PARAM_W-1:0]  out_param_reg;
    logic [HID_W-1:0]    out_hid_reg;
    logic [QCOUNT_W-1:0] out_count_reg;
    logic                out_last_reg;
    logic                out_free;

    assign out_free = !out_valid_reg || m_tready;

    // Pointer and count updates.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (cmd.q_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_Q) ? '0 : wr_ptr_reg + QIW'(1);
            count_next  = count_reg + CW'(1);
        end
        else if (cmd.q_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_Q) ? '0 : rd_ptr_reg + QIW'(1);
            count_next  = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (cmd.q_push)
        begin
            q_type_mem[wr_ptr_reg]  <= in_type;
            q_param_mem[wr_ptr_reg] <= in_param;
        end
        if (cmd.q_pop)
        begin
            ev_type_reg  <= q_type_mem[rd_ptr_reg];
            ev_param_reg <= q_param_mem[rd_ptr_reg];
        end
    end

    // Slot read address: slot zero at the start, then the next slot.
    assign sl_rd_en   = cmd.scan_start || cmd.scan_step;
    assign sl_rd_addr = cmd.scan_start ? '0 : chk_idx_reg + SLOT_IW'(1);

    // Slot table memory: written at the slot under check, read one ahead.
    always_ff @(posedge clk)
    begin
        if (cmd.slot_write)
        begin
            sl_type_mem[chk_idx_reg] <= req_type_reg;
            sl_hid_mem[chk_idx_reg]  <= req_hid_reg;
        end
        if (sl_rd_en)
        begin
            sl_type_reg <= sl_type_mem[sl_rd_addr];
            sl_hid_reg  <= sl_hid_mem[sl_rd_addr];
        end
    end

    // Occupancy bits clear at reset, so every slot starts free.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            sl_vld_reg  <= 1'b0;
            chk_idx_reg <= '0;
        end
        else
        begin
            if (cmd.slot_write)
            begin
                vld_reg[chk_idx_reg] <= 1'b1;
            end
            if (cmd.slot_free)
            begin
                vld_reg[chk_idx_reg] <= 1'b0;
            end
            if (sl_rd_en)
            begin
                sl_vld_reg  <= vld_reg[sl_rd_addr];
                chk_idx_reg <= sl_rd_addr;
            end
        end
    end

    // Request fields for subscribe and unsubscribe.
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            req_type_reg <= in_type;
            req_hid_reg  <= in_hid;
        end
        if (cmd.hold_load)
        begin
            hold_hid_reg <= sl_hid_reg;
        end
    end

    // Held dispatch hit and found flag for the running scan.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            found_reg      <= 1'b0;
        end
        else if (cmd.scan_start)
        begin
            hold_valid_reg <= 1'b0;
            found_reg      <= 1'b0;
        end
        else
        begin
            if (cmd.hold_load)
            begin
                hold_valid_reg <= 1'b1;
            end
            if (cmd.found_set)
            begin
                found_reg <= 1'b1;
            end
        end
    end

    // Output register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit != EM_NONE)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge clk)
    begin
        if (cmd.emit != EM_NONE)
        begin
            out_status_reg <= cmd.emit_status;
            out_last_reg   <= cmd.emit_last;
            out_count_reg  <= QCOUNT_W'(count_next);
            case (cmd.emit)
                EM_HIT:
                begin
                    out_type_reg  <= ev_type_reg;
                    out_param_reg <= ev_param_reg;
                    out_hid_reg   <= hold_hid_reg;
                end
                EM_MISS:
                begin
                    out_type_reg  <= ev_type_reg;
                    out_param_reg <= ev_param_reg;
                    out_hid_reg   <= '0;
                end
                default:
                begin
                    out_type_reg  <= '0;
                    out_param_reg <= '0;
                    out_hid_reg   <= '0;
                end
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {2'b00, out_count_reg, out_hid_reg, out_param_reg, out_type_reg};

    // Status towards the controller.
    always_comb
    begin
        stat.out_free     = out_free;
        stat.q_empty      = (count_reg == '0);
        stat.q_full       = (count_reg == FULL_CNT);
        stat.in_type_zero = (in_type == '0);
        stat.disp_hit     = sl_vld_reg && (sl_type_reg == ev_type_reg);
        stat.free_hit     = !sl_vld_reg;
        stat.unsub_hit    = sl_vld_reg && (sl_type_reg == req_type_reg)
                            && (sl_hid_reg == req_hid_reg);
        stat.chk_end      = (chk_idx_reg == LAST_SLOT);
        stat.hold_valid   = hold_valid_reg;
        stat.found        = found_reg;
    end

`ifndef SYNTHESIS
    a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.q_push |-> (count_reg != FULL_CNT))
        else $error("event pushed into a full queue");

    a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.q_pop |-> (count_reg != '0))
        else $error("event popped from an empty queue");

    a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (rd_ptr_reg == wr_ptr_reg))
        else $error("queue empty but pointers differ");

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit != EM_NONE) |-> out_free)
        else $error("result overwrites a beat not yet taken");
`endif

endmodule

// File: rtl/evq_ctrl.sv
module evq_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  evq_pkg::cmd_e      command,
    input  evq_pkg::evq_stat_t stat,
    output evq_pkg::evq_cmd_t  cmd
);
    import evq_pkg::*;

    state_e state_reg, state_next;
    cmd_e   cur_cmd_reg, cur_cmd_next;
    logic   accept;
    logic   disp_advance;

    assign accept       = (state_reg == S_IDLE) && s_tvalid && stat.out_free;
    // A second hit can only move on once the output register is free to take the held one.
    assign disp_advance = !(stat.disp_hit && stat.hold_valid && !stat.out_free);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            cur_cmd_reg <= CMD_POST;
        end
        else
        begin
            state_reg   <= state_next;
            cur_cmd_reg <= cur_cmd_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next   = state_reg;
        cur_cmd_next = accept ? command : cur_cmd_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (command)
                        CMD_DISPATCH:
                        begin
                            if (!stat.q_empty)
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        CMD_SUBSCRIBE:
                        begin
                            if (!stat.in_type_zero)
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        CMD_UNSUBSCRIBE:
                        begin
                            state_next = S_SCAN;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                case (cur_cmd_reg)
                    CMD_DISPATCH:
                    begin
                        if (disp_advance && stat.chk_end)
                        begin
                            state_next = S_FINAL;
                        end
                    end
                    CMD_SUBSCRIBE:
                    begin
                        if (stat.free_hit || stat.chk_end)
                        begin
                            state_next = S_FINAL;
                        end
                    end
                    CMD_UNSUBSCRIBE:
                    begin
                        if (stat.unsub_hit || stat.chk_end)
                        begin
                            state_next = S_FINAL;
                        end
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_FINAL:
            begin
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Outputs.
    always_comb
    begin
        s_tready = 1'b0;
        cmd      = '0;
        case (state_reg)
            S_IDLE:
            begin
                s_tready   = stat.out_free;
                cmd.accept = accept;
                if (accept)
                begin
                    case (command)
                        CMD_POST:
                        begin
                            cmd.emit      = EM_PLAIN;
                            cmd.emit_last = 1'b1;
                            if (stat.in_type_zero)
                            begin
                                cmd.emit_status = STAT_TYPE_ZERO;
                            end
                            else if (stat.q_full)
                            begin
                                cmd.emit_status = STAT_QUEUE_FULL;
                            end
                            else
                            begin
                                cmd.q_push      = 1'b1;
                                cmd.emit_status = STAT_OK;
                            end
                        end
                        CMD_DISPATCH:
                        begin
                            if (stat.q_empty)
                            begin
                                cmd.emit        = EM_PLAIN;
                                cmd.emit_status = STAT_EMPTY;
                                cmd.emit_last   = 1'b1;
                            end
                            else
                            begin
                                cmd.q_pop      = 1'b1;
                                cmd.scan_start = 1'b1;
                            end
                        end
                        CMD_SUBSCRIBE:
                        begin
                            if (stat.in_type_zero)
                            begin
                                cmd.emit        = EM_PLAIN;
                                cmd.emit_status = STAT_TYPE_ZERO;
                                cmd.emit_last   = 1'b1;
                            end
                            else
                            begin
                                cmd.scan_start = 1'b1;
                            end
                        end
                        CMD_UNSUBSCRIBE:
                        begin
                            cmd.scan_start = 1'b1;
                        end
                        default:
                        begin
                            cmd.scan_start = 1'b0;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                case (cur_cmd_reg)
                    CMD_DISPATCH:
                    begin
                        if (disp_advance)
                        begin
                            cmd.scan_step = !stat.chk_end;
                            if (stat.disp_hit)
                            begin
                                cmd.hold_load = 1'b1;
                                if (stat.hold_valid)
                                begin
                                    cmd.emit        = EM_HIT;
                                    cmd.emit_status = STAT_OK;
                                end
                            end
                        end
                    end
                    CMD_SUBSCRIBE:
                    begin
                        if (stat.free_hit)
                        begin
                            cmd.slot_write = 1'b1;
                            cmd.found_set  = 1'b1;
                        end
                        else
                        begin
                            cmd.scan_step = !stat.chk_end;
                        end
                    end
                    CMD_UNSUBSCRIBE:
                    begin
                        if (stat.unsub_hit)
                        begin
                            cmd.slot_free = 1'b1;
                            cmd.found_set = 1'b1;
                        end
                        else
                        begin
                            cmd.scan_step = !stat.chk_end;
                        end
                    end
                    default:
                    begin
                        cmd.scan_step = 1'b0;
                    end
                endcase
            end
            S_FINAL:
            begin
                if (stat.out_free)
                begin
                    cmd.emit      = EM_PLAIN;
                    cmd.emit_last = 1'b1;
                    case (cur_cmd_reg)
                        CMD_DISPATCH:
                        begin
                            if (stat.hold_valid)
                            begin
                                cmd.emit        = EM_HIT;
                                cmd.emit_status = STAT_OK;
                            end
                            else
                            begin
                                cmd.emit        = EM_MISS;
                                cmd.emit_status = STAT_EMPTY;
                            end
                        end
                        CMD_SUBSCRIBE:
                        begin
                            cmd.emit_status = stat.found ? STAT_OK : STAT_TABLE_FULL;
                        end
                        CMD_UNSUBSCRIBE:
                        begin
                            cmd.emit_status = stat.found ? STAT_OK : STAT_NO_HANDLER;
                        end
                        default:
                        begin
                            cmd.emit_status = STAT_OK;
                        end
                    endcase
                end
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

// File: rtl/event_queue_dispatcher.sv
// Channel   Direction  Beat contents
// s_*       in         tuser: command; tdata: event_type, event_param, handler_id
// m_*       out        tuser: status; tdata: out_type, out_param, out_handler,
//                      queue_count; tlast: last
//
// For a post, a dispatch on an empty queue and a subscribe of type zero, the
// result is loaded on the beat that accepts the command. Dispatch, subscribe
// and unsubscribe walk the subscriber table one slot per cycle through its
// single read port, but a dispatch pauses while a second hit waits for the
// output register. A new command is accepted only in idle, with that register free.
// Reset is asynchronous and active low; it empties the queue and frees
// every slot at once, with no clearing pass.
module event_queue_dispatcher #(
    parameter int QUEUE_DEPTH = 32,
    parameter int TABLE_SLOTS = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [7:0] event_type, [23:8] event_param, [31:24] handler_id
    input  logic [evq_pkg::IN_DATA_W-1:0]  s_tdata,
    // [1:0] command
    input  logic [evq_pkg::CMD_W-1:0]      s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [7:0] out_type, [23:8] out_param, [31:24] out_handler,
    // [37:32] queue_count, [39:38] zero
    output logic [evq_pkg::OUT_DATA_W-1:0] m_tdata,
    // [2:0] status
    output logic [evq_pkg::STATUS_W-1:0]   m_tuser,
    output logic                           m_tlast
);
    import evq_pkg::*;

    evq_cmd_t  dp_cmd;
    evq_stat_t dp_stat;
    cmd_e      command;

    assign command = cmd_e'(s_tuser);

    evq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .command  (command),
        .stat     (dp_stat),
        .cmd      (dp_cmd)
    );

    evq_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .TABLE_SLOTS (TABLE_SLOTS)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .cmd      (dp_cmd),
        .stat     (dp_stat),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

// File: tb/evq_dispatch_checker.sv
`timescale 1ns / 100ps

// Watches both stream channels of the event queue dispatcher, predicts the
// result beats of every accepted command and compares them in order.
module evq_dispatch_checker #(
    parameter int QUEUE_DEPTH = 32,
    parameter int TABLE_SLOTS = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [evq_pkg::IN_DATA_W-1:0]  s_tdata,
    input  logic [evq_pkg::CMD_W-1:0]      s_tuser,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [evq_pkg::OUT_DATA_W-1:0] m_tdata,
    input  logic [evq_pkg::STATUS_W-1:0]   m_tuser,
    input  logic                           m_tlast,
    output int                             failures,
    output int                             outstanding,
    output int                             beats_checked,
    output int                             widest_fanout
);
    import evq_pkg::*;

    // One predicted result beat.
    typedef struct packed {
        status_e             status;
        logic [TYPE_W-1:0]   evt_type;
        logic [PARAM_W-1:0]  evt_param;
        logic [HID_W-1:0]    handler;
        logic [QCOUNT_W-1:0] queued;
        logic                last;
    } dispatch_result_t;

    dispatch_result_t   expected_results[$];

    // Shadow copy of the event ring and the subscriber slots.
    logic [TYPE_W-1:0]  ring_types  [QUEUE_DEPTH];
    logic [PARAM_W-1:0] ring_params [QUEUE_DEPTH];
    int                 rd_idx;
    int                 wr_idx;
    int                 pend_count;
    logic [TYPE_W-1:0]  sub_types    [TABLE_SLOTS];
    logic [HID_W-1:0]   sub_handlers [TABLE_SLOTS];

    int fail_count   = 0;
    int checked      = 0;
    int max_fanout   = 0;

    // Appends one expected beat, carrying the queue level after the step.
    function automatic void queue_result(status_e st, logic [TYPE_W-1:0] et,
                                         logic [PARAM_W-1:0] ep,
                                         logic [HID_W-1:0] hid, logic lst);
        dispatch_result_t r;
        r.status    = st;
        r.evt_type  = et;
        r.evt_param = ep;
        r.handler   = hid;
        r.queued    = QCOUNT_W'(pend_count);
        r.last      = lst;
        expected_results.push_back(r);
    endfunction

    // Applies one command to the shadow state and queues its results.
    function automatic void predict_command(cmd_e cmd, logic [TYPE_W-1:0] et,
                                            logic [PARAM_W-1:0] ep,
                                            logic [HID_W-1:0] hid);
        logic [TYPE_W-1:0]  head_type;
        logic [PARAM_W-1:0] head_param;
        status_e            st;
        int                 hits;
        hits = 0;
        case (cmd)
            CMD_POST:
            begin
                if (et == '0)
                    st = STAT_TYPE_ZERO;
                else if (pend_count >= QUEUE_DEPTH)
                    st = STAT_QUEUE_FULL;
                else
                begin
                    ring_types[wr_idx]  = et;
                    ring_params[wr_idx] = ep;
                    wr_idx = (wr_idx + 1) % QUEUE_DEPTH;
                    pend_count++;
                    st = STAT_OK;
                end
                queue_result(st, '0, '0, '0, 1'b1);
            end
            CMD_DISPATCH:
            begin
                if (pend_count == 0)
                    queue_result(STAT_EMPTY, '0, '0, '0, 1'b1);
                else
                begin
                    head_type  = ring_types[rd_idx];
                    head_param = ring_params[rd_idx];
                    rd_idx = (rd_idx + 1) % QUEUE_DEPTH;
                    pend_count--;
                    // Every occupied slot of the popped type gets a beat, in slot order.
                    for (int i = 0; i < TABLE_SLOTS; i++)
                    begin
                        if (sub_types[i] != '0 && sub_types[i] == head_type)
                        begin
                            queue_result(STAT_OK, head_type, head_param, sub_handlers[i],
                                         1'b0);
                            hits++;
                        end
                    end
                    if (hits == 0)
                        queue_result(STAT_EMPTY, head_type, head_param, '0, 1'b1);
                    else
                        expected_results[expected_results.size() - 1].last = 1'b1;
                    if (hits > max_fanout)
                        max_fanout = hits;
                end
            end
            CMD_SUBSCRIBE:
            begin
                st = STAT_TABLE_FULL;
                if (et == '0)
                    st = STAT_TYPE_ZERO;
                else
                begin
                    for (int i = 0; i < TABLE_SLOTS; i++)
                    begin
                        if (st != STAT_OK && sub_types[i] == '0)
                        begin
                            sub_types[i]    = et;
                            sub_handlers[i] = hid;
                            st = STAT_OK;
                        end
                    end
                end
                queue_result(st, '0, '0, '0, 1'b1);
            end
            default:
            begin
                // Unsubscribe frees only the first slot matching type and handler.
                st = STAT_NO_HANDLER;
                for (int i = 0; i < TABLE_SLOTS; i++)
                begin
                    if (st != STAT_OK && sub_types[i] != '0 && sub_types[i] == et &&
                        sub_handlers[i] == hid)
                    begin
                        sub_types[i]    = '0;
                        sub_handlers[i] = '0;
                        st = STAT_OK;
                    end
                end
                queue_result(st, '0, '0, '0, 1'b1);
            end
        endcase
    endfunction

    function automatic void compare_field(string field, int unsigned want,
                                          int unsigned got);
        if (want != got)
        begin
            fail_count++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
        end
    endfunction

    // Result beats are checked before the command beat of the same edge is
    // predicted, so a beat can never be matched against its own command.
    always @(posedge clk)
    begin
        dispatch_result_t want;
        if (!rst_n)
        begin
            rd_idx     = 0;
            wr_idx     = 0;
            pend_count = 0;
            for (int i = 0; i < QUEUE_DEPTH; i++)
            begin
                ring_types[i]  = '0;
                ring_params[i] = '0;
            end
            for (int i = 0; i < TABLE_SLOTS; i++)
            begin
                sub_types[i]    = '0;
                sub_handlers[i] = '0;
            end
            expected_results.delete();
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                checked++;
                if (expected_results.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: unexpected result beat, expected none, got status %0d data %h last %b",
                             $time, m_tuser, m_tdata, m_tlast);
                end
                else
                begin
                    want = expected_results.pop_front();
                    compare_field("status", want.status, m_tuser);
                    compare_field("out_type", want.evt_type, m_tdata[7:0]);
                    compare_field("out_param", want.evt_param, m_tdata[23:8]);
                    compare_field("out_handler", want.handler, m_tdata[31:24]);
                    compare_field("queue_count", want.queued, m_tdata[37:32]);
                    compare_field("last", want.last, m_tlast);
                end
            end
            if (s_tvalid && s_tready)
                predict_command(cmd_e'(s_tuser), s_tdata[7:0], s_tdata[23:8],
                                s_tdata[31:24]);
        end
        failures      <= fail_count;
        outstanding   <= expected_results.size();
        beats_checked <= checked;
        widest_fanout <= max_fanout;
    end

endmodule

// File: tb/tb_event_queue_dispatcher.sv
`timescale 1ns / 100ps

module tb_event_queue_dispatcher;

    import evq_pkg::*;

    localparam int QUEUE_DEPTH    = 32;
    localparam int TABLE_SLOTS    = 32;
    localparam int RANDOM_BLOCKS  = 10;
    localparam int BLOCK_ITEMS    = 44;
    localparam int WATCHDOG_LIMIT = 5000;

    // Traffic shape of one block of random commands.
    typedef enum int {
        MIX_FILL_TABLE,
        MIX_FILL_QUEUE,
        MIX_DRAIN,
        MIX_BALANCED
    } traffic_mix_e;

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata  = '0;
    logic [CMD_W-1:0]      s_tuser  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b1;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [STATUS_W-1:0]   m_tuser;
    logic                  m_tlast;

    int failures;
    int outstanding;
    int beats_checked;
    int widest_fanout;
    int items_sent  = 0;
    int idle_cycles = 0;
    bit quiet       = 1'b0;

    event_queue_dispatcher #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .TABLE_SLOTS (TABLE_SLOTS)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    evq_dispatch_checker #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .TABLE_SLOTS (TABLE_SLOTS)
    ) checker_inst (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .m_tlast       (m_tlast),
        .failures      (failures),
        .outstanding   (outstanding),
        .beats_checked (beats_checked),
        .widest_fanout (widest_fanout)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // The receiver stalls now and then, except during the quiet stretch.
    always @(negedge clk)
    begin
        m_tready <= quiet || ($urandom_range(99) >= 8);
    end

    // Ends the run if the block stops moving beats altogether.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no beat moved for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("Test completed with failures");
            $finish;
        end
    end

    // Offers one command beat, with an occasional gap first, and returns at
    // the falling edge after it has been taken.
    task automatic send_item(input cmd_e cmd, input logic [TYPE_W-1:0] evt,
                             input logic [PARAM_W-1:0] prm,
                             input logic [HID_W-1:0] hid);
        while (!quiet && $urandom_range(99) < 8)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {hid, prm, evt};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        items_sent++;
        @(negedge clk);
    endtask

    // Mostly a handful of types so that subscriptions meet posts; the rest
    // covers the reserved type and the whole range.
    function automatic logic [TYPE_W-1:0] pick_type();
        int roll;
        roll = $urandom_range(99);
        if (roll < 8)
            return '0;
        if (roll < 78)
            return TYPE_W'($urandom_range(4, 1));
        return TYPE_W'($urandom_range(255));
    endfunction

    function automatic logic [HID_W-1:0] pick_handler();
        if ($urandom_range(99) < 70)
            return HID_W'($urandom_range(3));
        return HID_W'($urandom_range(255));
    endfunction

    function automatic cmd_e pick_command(traffic_mix_e mix);
        int roll;
        roll = $urandom_range(99);
        case (mix)
            MIX_FILL_TABLE:
                return (roll < 90) ? CMD_SUBSCRIBE : CMD_POST;
            MIX_FILL_QUEUE:
                return (roll < 95) ? CMD_POST : CMD_DISPATCH;
            MIX_DRAIN:
            begin
                if (roll < 60)
                    return CMD_DISPATCH;
                if (roll < 90)
                    return CMD_UNSUBSCRIBE;
                return CMD_POST;
            end
            default:
                return cmd_e'(CMD_W'(roll));
        endcase
    endfunction

    initial
    begin
        traffic_mix_e mix;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Refusals and empty cases on a freshly reset block.
        send_item(CMD_DISPATCH, 8'h00, 16'h0000, 8'h00);
        send_item(CMD_POST, 8'h00, 16'hFFFF, 8'h00);
        send_item(CMD_SUBSCRIBE, 8'h00, 16'h0000, 8'hFF);
        send_item(CMD_UNSUBSCRIBE, 8'h00, 16'h0000, 8'h00);
        send_item(CMD_UNSUBSCRIBE, 8'h11, 16'h0000, 8'h05);

        // Subscriptions at the extremes, then hits, a single hit and a miss.
        send_item(CMD_SUBSCRIBE, 8'hFF, 16'h0000, 8'hFF);
        send_item(CMD_SUBSCRIBE, 8'hFF, 16'h0000, 8'h00);
        send_item(CMD_SUBSCRIBE, 8'h01, 16'h0000, 8'hA5);
        send_item(CMD_POST, 8'hFF, 16'hFFFF, 8'h00);
        send_item(CMD_POST, 8'h01, 16'h0000, 8'hFF);
        send_item(CMD_POST, 8'h80, 16'h5A5A, 8'h00);
        send_item(CMD_DISPATCH, 8'h00, 16'h0000, 8'h00);
        send_item(CMD_DISPATCH, 8'hFF, 16'hFFFF, 8'hFF);
        send_item(CMD_DISPATCH, 8'h00, 16'h0000, 8'h00);

        // Freeing a slot, freeing it twice, and refilling the first free slot.
        send_item(CMD_UNSUBSCRIBE, 8'hFF, 16'h0000, 8'h00);
        send_item(CMD_UNSUBSCRIBE, 8'hFF, 16'h0000, 8'h00);
        send_item(CMD_SUBSCRIBE, 8'hFF, 16'h0000, 8'h5A);
        send_item(CMD_POST, 8'hFF, 16'h8001, 8'h00);
        send_item(CMD_DISPATCH, 8'h00, 16'h0000, 8'h00);
        send_item(CMD_UNSUBSCRIBE, 8'h01, 16'h0000, 8'h5A);
        send_item(CMD_UNSUBSCRIBE, 8'h01, 16'h0000, 8'hA5);
        send_item(CMD_DISPATCH, 8'h00, 16'h0000, 8'h00);

        // Random blocks that fill the table and the queue past their limits
        // and drain them again, with a quiet stretch in the middle.
        for (int blk = 0; blk < RANDOM_BLOCKS; blk++)
        begin
            mix   = traffic_mix_e'(blk % 4);
            quiet = (blk == 3) || (blk == 4);
            for (int n = 0; n < BLOCK_ITEMS; n++)
                send_item(pick_command(mix), pick_type(), PARAM_W'($urandom),
                          pick_handler());
        end
        quiet = 1'b0;
        s_tvalid <= 1'b0;

        // Let every predicted beat arrive, then watch for strays.
        while (outstanding != 0)
            @(posedge clk);
        repeat (TABLE_SLOTS + 4) @(posedge clk);

        $display("Sent %0d commands across post, dispatch, subscribe and unsubscribe;",
                 items_sent);
        $display("checked %0d result beats, widest dispatch fan-out %0d handlers.",
                 beats_checked, widest_fanout);
        if (failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
